@@ rtl/i2c_master_message_sequencer_assert.svh @@
// assertion macros used by the sequencer datapath
`ifndef I2C_MASTER_MESSAGE_SEQUENCER_ASSERT_SVH
`define I2C_MASTER_MESSAGE_SEQUENCER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define I2CMS_ASSERT_IMP(lbl, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);

// next-cycle implication, checked outside reset
`define I2CMS_ASSERT_NXT(lbl, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);

`endif

@@ rtl/i2cms_pkg.sv @@
// ----------------------------------------------------------------------------
// i2cms_pkg
// types, codes and control structs shared by the message sequencer modules
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package i2cms_pkg;

  localparam int MAX_MSGS   = 16;
  localparam int DATA_DEPTH = 256;
  localparam int MSG_W      = $clog2(MAX_MSGS);
  localparam int DATA_AW    = $clog2(DATA_DEPTH);
  localparam int CNT_W      = MSG_W + 1;

  typedef enum logic [1:0] {
    CMD_LOAD_DESC = 2'd0,
    CMD_LOAD_DATA = 2'd1,
    CMD_START     = 2'd2,
    CMD_EVENT     = 2'd3
  } cmd_t;

  // descriptor flag bits
  localparam int F_RD      = 0;
  localparam int F_STOP    = 1;
  localparam int F_NOSTART = 2;
  localparam int F_IGNAK   = 3;

  // core event bits
  localparam int E_ACK     = 0;
  localparam int E_NACK    = 1;
  localparam int E_RXDATAV = 2;
  localparam int E_MSTOP   = 4;
  localparam logic [7:0] E_ERRS = 8'hE0;

  // core command bits
  localparam logic [5:0] C_START = 6'h01;
  localparam logic [5:0] C_STOP  = 6'h02;
  localparam logic [5:0] C_ACK   = 6'h04;
  localparam logic [5:0] C_NACK  = 6'h08;
  localparam logic [5:0] C_CONT  = 6'h10;
  localparam logic [5:0] C_ABORT = 6'h20;

  // completion status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_ERR     = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

  typedef enum logic [1:0] {
    RD_CUR,
    RD_SUCC,
    RD_ZERO,
    RD_IDXN
  } rd_sel_t;

  typedef struct packed {
    logic [6:0] addr;
    logic [3:0] flags;
    logic [8:0] len;
    logic [7:0] off;
  } desc_t;

  typedef struct packed {
    logic       desc_we;
    logic       data_we;
    logic       chk_clr;
    logic       chk_step;
    logic       start_go;
    logic       cache_ld;
    logic       load_msg;
    logic       cur_succ;
    logic       bytes_clr;
    logic       store_rx;
    logic       tx_data;
    logic       send_addr;
    logic       set_early;
    logic       clr_early;
    logic       active_clr;
    logic       finish;
    logic [1:0] fin_status;
    logic [5:0] cmd_or;
    rd_sel_t    rd_sel;
    logic       out_load;
  } ctl_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] ev;
    logic       active;
    logic       early;
    logic       n_ok;
    logic       bytes_zero;
    logic       msgs_zero;
    logic       msgs_one;
    logic       i_zero;
    logic       i_last;
    logic [3:0] cache_flags;
    logic [3:0] rd_flags;
    logic [3:0] prev_flags;
    logic       rd_len_nz;
    logic       out_free;
  } sts_t;

endpackage

@@ rtl/i2c_master_message_sequencer.sv @@
// ----------------------------------------------------------------------------
// i2c_master_message_sequencer
// walks an i2c master core through a list of message descriptors
// ----------------------------------------------------------------------------
//  channel  direction  handshake             payload
//  in_      input      in_valid / in_stall   command word and core event
//  out_     output     out_valid / out_stall one result word per input word
//
//  a start reads every descriptor of the transfer; an event takes longer
//  for every descriptor visited while skipping or advancing over empty
//  continuation messages (descriptor store with registered read, one lookup
//  at a time)
//  reset clears the transfer state; both stores hold garbage until loaded
//  a stalled result waits in the output register while the next word is taken
`timescale 1ns / 1ps

module i2c_master_message_sequencer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_cmd,
  input  logic [3:0] in_msg_index,
  input  logic [6:0] in_msg_slave_addr,
  input  logic [3:0] in_msg_flags,
  input  logic [8:0] in_msg_len,
  input  logic [7:0] in_msg_offset,
  input  logic [7:0] in_data_index,
  input  logic [7:0] in_data_byte,
  input  logic [4:0] in_transfer_msg_count,
  input  logic [7:0] in_event_flags,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [5:0] out_core_command,
  output logic       out_tx_valid,
  output logic [7:0] out_tx_byte,
  output logic       out_rx_valid,
  output logic [7:0] out_rx_index,
  output logic [7:0] out_rx_data,
  output logic       out_done_res,
  output logic [1:0] out_status,
  output logic       out_busy_res
);

  i2cms_pkg::ctl_t ctl;
  i2cms_pkg::sts_t sts;

  // sequencing controller
  i2cms_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .ctl      (ctl),
    .sts      (sts)
  );

  // stores and result datapath
  i2cms_dp u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_cmd                (in_cmd),
    .in_msg_index          (in_msg_index),
    .in_msg_slave_addr     (in_msg_slave_addr),
    .in_msg_flags          (in_msg_flags),
    .in_msg_len            (in_msg_len),
    .in_msg_offset         (in_msg_offset),
    .in_data_index         (in_data_index),
    .in_data_byte          (in_data_byte),
    .in_transfer_msg_count (in_transfer_msg_count),
    .in_event_flags        (in_event_flags),
    .in_rx_byte            (in_rx_byte),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_core_command      (out_core_command),
    .out_tx_valid          (out_tx_valid),
    .out_tx_byte           (out_tx_byte),
    .out_rx_valid          (out_rx_valid),
    .out_rx_index          (out_rx_index),
    .out_rx_data           (out_rx_data),
    .out_done_res          (out_done_res),
    .out_status            (out_status),
    .out_busy_res          (out_busy_res),
    .ctl                   (ctl),
    .sts                   (sts)
  );

endmodule

@@ rtl/i2cms_dp.sv @@
// ----------------------------------------------------------------------------
// i2cms_dp
// datapath: descriptor and byte stores, transfer registers, result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "i2c_master_message_sequencer_assert.svh"

module i2cms_dp (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_stall,
  input  logic [1:0]       in_cmd,
  input  logic [3:0]       in_msg_index,
  input  logic [6:0]       in_msg_slave_addr,
  input  logic [3:0]       in_msg_flags,
  input  logic [8:0]       in_msg_len,
  input  logic [7:0]       in_msg_offset,
  input  logic [7:0]       in_data_index,
  input  logic [7:0]       in_data_byte,
  input  logic [4:0]       in_transfer_msg_count,
  input  logic [7:0]       in_event_flags,
  input  logic [7:0]       in_rx_byte,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [5:0]       out_core_command,
  output logic             out_tx_valid,
  output logic [7:0]       out_tx_byte,
  output logic             out_rx_valid,
  output logic [7:0]       out_rx_index,
  output logic [7:0]       out_rx_data,
  output logic             out_done_res,
  output logic [1:0]       out_status,
  output logic             out_busy_res,
  input  i2cms_pkg::ctl_t  ctl,
  output i2cms_pkg::sts_t  sts
);

  logic take;
  assign take = in_valid && !in_stall;

  // captured item
  i2cms_pkg::cmd_t  cmd_r;
  logic [3:0]       msg_index_r;
  logic [6:0]       msg_slave_addr_r;
  logic [3:0]       msg_flags_r;
  logic [8:0]       msg_len_r;
  logic [7:0]       msg_offset_r;
  logic [7:0]       data_index_r;
  logic [7:0]       data_byte_r;
  logic [4:0]       msg_count_r;
  logic [7:0]       event_flags_r;
  logic [7:0]       rx_byte_r;

  always_ff @(posedge clk) begin
    if (take) begin
      cmd_r            <= i2cms_pkg::cmd_t'(in_cmd);
      msg_index_r      <= in_msg_index;
      msg_slave_addr_r <= in_msg_slave_addr;
      msg_flags_r      <= in_msg_flags;
      msg_len_r        <= in_msg_len;
      msg_offset_r     <= in_msg_offset;
      data_index_r     <= in_data_index;
      data_byte_r      <= in_data_byte;
      msg_count_r      <= in_transfer_msg_count;
      event_flags_r    <= in_event_flags;
      rx_byte_r        <= in_rx_byte;
    end
  end

  // transfer registers
  logic [i2cms_pkg::MSG_W-1:0]   cur_r;
  logic [i2cms_pkg::CNT_W-1:0]   msgs_left_r;
  logic [i2cms_pkg::DATA_AW-1:0] buf_pos_r;
  logic [8:0]                    bytes_left_r;
  logic                          early_r;
  logic                          active_r;
  logic [i2cms_pkg::CNT_W-1:0]   i_r;
  logic [i2cms_pkg::CNT_W-1:0]   i_nxt;
  logic [3:0]                    prev_flags_r;
  i2cms_pkg::desc_t              cache_r;
  i2cms_pkg::desc_t              desc_rd_r;
  logic [7:0]                    data_rd_r;
  logic [i2cms_pkg::MSG_W-1:0]   succ;

  assign succ  = cur_r + 1'b1;
  assign i_nxt = i_r + 1'b1;

  // descriptor store, one write and one registered read
  i2cms_pkg::desc_t            desc_mem [i2cms_pkg::MAX_MSGS];
  logic [i2cms_pkg::MSG_W-1:0] desc_ra;

  always_comb begin
    unique case (ctl.rd_sel)
      i2cms_pkg::RD_CUR:  desc_ra = cur_r;
      i2cms_pkg::RD_SUCC: desc_ra = succ;
      i2cms_pkg::RD_ZERO: desc_ra = '0;
      i2cms_pkg::RD_IDXN: desc_ra = i_nxt[i2cms_pkg::MSG_W-1:0];
      default:            desc_ra = cur_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.desc_we) begin
      desc_mem[msg_index_r] <= '{addr: msg_slave_addr_r, flags: msg_flags_r,
                                 len: msg_len_r, off: msg_offset_r};
    end
    desc_rd_r <= desc_mem[desc_ra];
  end

  // byte store, written by loads and by received bytes, read at buffer position
  logic [7:0]                    data_mem [i2cms_pkg::DATA_DEPTH];
  logic [i2cms_pkg::DATA_AW-1:0] data_wa;
  logic [7:0]                    data_wd;

  assign data_wa = ctl.data_we ? data_index_r : buf_pos_r;
  assign data_wd = ctl.data_we ? data_byte_r : rx_byte_r;

  always_ff @(posedge clk) begin
    if (ctl.data_we || ctl.store_rx) begin
      data_mem[data_wa] <= data_wd;
    end
    data_rd_r <= data_mem[buf_pos_r];
  end

  // sequencing state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r        <= '0;
      msgs_left_r  <= '0;
      buf_pos_r    <= '0;
      bytes_left_r <= '0;
      early_r      <= 1'b0;
      active_r     <= 1'b0;
      i_r          <= '0;
    end else begin
      if (ctl.start_go) begin
        cur_r       <= '0;
        msgs_left_r <= msg_count_r;
        active_r    <= 1'b1;
        early_r     <= 1'b0;
      end
      if (ctl.cur_succ) begin
        cur_r       <= succ;
        msgs_left_r <= msgs_left_r - 1'b1;
      end
      if (ctl.load_msg) begin
        buf_pos_r    <= desc_rd_r.off;
        bytes_left_r <= desc_rd_r.len;
      end else if (ctl.bytes_clr) begin
        bytes_left_r <= '0;
      end else if (ctl.store_rx || ctl.tx_data) begin
        buf_pos_r    <= buf_pos_r + 1'b1;
        bytes_left_r <= bytes_left_r - 1'b1;
      end
      if (ctl.set_early) early_r <= 1'b1;
      if (ctl.clr_early) early_r <= 1'b0;
      if (ctl.active_clr) active_r <= 1'b0;
      if (ctl.chk_clr) i_r <= '0;
      else if (ctl.chk_step) i_r <= i_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.cache_ld) cache_r <= desc_rd_r;
    if (ctl.chk_step) prev_flags_r <= desc_rd_r.flags;
  end

  // per-item result accumulators
  logic [5:0] cmd_acc_r;
  logic       txv_r;
  logic [7:0] txb_r;
  logic       rxv_r;
  logic [7:0] rxi_r;
  logic [7:0] rxd_r;
  logic       done_r;
  logic [1:0] st_r;

  always_ff @(posedge clk) begin
    if (take) begin
      cmd_acc_r <= '0;
      txv_r     <= 1'b0;
      txb_r     <= '0;
      rxv_r     <= 1'b0;
      rxi_r     <= '0;
      rxd_r     <= '0;
      done_r    <= 1'b0;
      st_r      <= i2cms_pkg::ST_OK;
    end else begin
      cmd_acc_r <= cmd_acc_r | ctl.cmd_or | (ctl.send_addr ? i2cms_pkg::C_START : 6'h00);
      if (ctl.send_addr) begin
        txv_r <= 1'b1;
        txb_r <= {cache_r.addr, cache_r.flags[i2cms_pkg::F_RD]};
      end else if (ctl.tx_data) begin
        txv_r <= 1'b1;
        txb_r <= data_rd_r;
      end
      if (ctl.store_rx) begin
        rxv_r <= 1'b1;
        rxi_r <= buf_pos_r;
        rxd_r <= rx_byte_r;
      end
      if (ctl.finish) begin
        done_r <= 1'b1;
        st_r   <= ctl.fin_status;
      end
    end
  end

  // result register
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      out_core_command <= cmd_acc_r;
      out_tx_valid     <= txv_r;
      out_tx_byte      <= txb_r;
      out_rx_valid     <= rxv_r;
      out_rx_index     <= rxi_r;
      out_rx_data      <= rxd_r;
      out_done_res     <= done_r;
      out_status       <= st_r;
      out_busy_res     <= active_r;
    end
  end

  assign out_valid = out_valid_r;

  // status to the controller
  always_comb begin
    sts.cmd         = cmd_r;
    sts.ev          = event_flags_r;
    sts.active      = active_r;
    sts.early       = early_r;
    sts.n_ok        = (msg_count_r != '0) &&
                      (msg_count_r <= 5'(i2cms_pkg::MAX_MSGS));
    sts.bytes_zero  = (bytes_left_r == '0);
    sts.msgs_zero   = (msgs_left_r == '0);
    sts.msgs_one    = (msgs_left_r == i2cms_pkg::CNT_W'(1));
    sts.i_zero      = (i_r == '0);
    sts.i_last      = (i_nxt == msg_count_r);
    sts.cache_flags = cache_r.flags;
    sts.rd_flags    = desc_rd_r.flags;
    sts.prev_flags  = prev_flags_r;
    sts.rd_len_nz   = (desc_rd_r.len != '0);
    sts.out_free    = !out_valid_r || !out_stall;
  end

  // checks
  `I2CMS_ASSERT_IMP(a_no_underflow, ctl.store_rx || ctl.tx_data, bytes_left_r != '0, "byte count underflow")
  `I2CMS_ASSERT_IMP(a_start_idle, ctl.start_go, !active_r, "transfer started while active")
  `I2CMS_ASSERT_NXT(a_out_loaded, ctl.out_load, out_valid_r, "result word not held")

endmodule

@@ rtl/i2cms_ctrl.sv @@
// ----------------------------------------------------------------------------
// i2cms_ctrl
// controller: steps one input word through loads, start checks and event handling
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module i2cms_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  output i2cms_pkg::ctl_t  ctl,
  input  i2cms_pkg::sts_t  sts
);

  typedef enum logic [4:0] {
    S_IDLE, S_DISP, S_ST_RD, S_ST_LD, S_ST_SA,
    S_EV_LD, S_A1, S_A2, S_A2B, S_A3, S_A4,
    S_B, S_B2, S_B3, S_B4, S_C, S_C2,
    S_SK_RD, S_SK_CHK, S_AD_CHK, S_AD_RD, S_OUT
  } state_t;

  state_t state_r, state_nxt;
  state_t ret_r, ret_nxt;

  logic chk_bad;
  logic skip_go;
  logic adv_brk;

  // start check on the descriptor just read
  assign chk_bad = sts.rd_flags[i2cms_pkg::F_NOSTART] &&
                   (sts.i_zero ||
                    (sts.prev_flags[i2cms_pkg::F_RD] != sts.rd_flags[i2cms_pkg::F_RD]) ||
                    sts.prev_flags[i2cms_pkg::F_STOP]);

  // continuation skip and advance stop conditions
  assign skip_go = !sts.msgs_zero && !sts.msgs_one &&
                   !sts.cache_flags[i2cms_pkg::F_STOP] &&
                   sts.rd_flags[i2cms_pkg::F_NOSTART] && sts.bytes_zero;
  assign adv_brk = sts.rd_len_nz || sts.rd_flags[i2cms_pkg::F_STOP] ||
                   !sts.rd_flags[i2cms_pkg::F_NOSTART];

  assign in_stall = (state_r != S_IDLE);

  // next state and commands
  always_comb begin
    state_nxt  = state_r;
    ret_nxt    = ret_r;
    ctl        = '0;
    ctl.rd_sel = i2cms_pkg::RD_CUR;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DISP;
      end
      S_DISP: begin
        unique case (sts.cmd)
          i2cms_pkg::CMD_LOAD_DESC: begin
            ctl.desc_we = 1'b1;
            state_nxt   = S_OUT;
          end
          i2cms_pkg::CMD_LOAD_DATA: begin
            ctl.data_we = 1'b1;
            state_nxt   = S_OUT;
          end
          i2cms_pkg::CMD_START: begin
            if (sts.active) begin
              state_nxt = S_OUT;
            end else if (!sts.n_ok) begin
              ctl.finish     = 1'b1;
              ctl.fin_status = i2cms_pkg::ST_INVALID;
              state_nxt      = S_OUT;
            end else begin
              ctl.chk_clr = 1'b1;
              ctl.rd_sel  = i2cms_pkg::RD_ZERO;
              state_nxt   = S_ST_RD;
            end
          end
          i2cms_pkg::CMD_EVENT: begin
            state_nxt = sts.active ? S_EV_LD : S_OUT;
          end
          default: state_nxt = S_OUT;
        endcase
      end
      S_ST_RD: begin
        if (chk_bad) begin
          ctl.finish     = 1'b1;
          ctl.fin_status = i2cms_pkg::ST_INVALID;
          state_nxt      = S_OUT;
        end else begin
          ctl.chk_step = 1'b1;
          if (sts.i_last) begin
            ctl.rd_sel = i2cms_pkg::RD_ZERO;
            state_nxt  = S_ST_LD;
          end else begin
            ctl.rd_sel = i2cms_pkg::RD_IDXN;
          end
        end
      end
      S_ST_LD: begin
        ctl.cache_ld = 1'b1;
        ctl.load_msg = 1'b1;
        ctl.start_go = 1'b1;
        state_nxt    = S_ST_SA;
      end
      S_ST_SA: begin
        ctl.send_addr = 1'b1;
        state_nxt     = S_OUT;
      end
      // fresh copy of the current descriptor has arrived
      S_EV_LD: begin
        ctl.cache_ld = 1'b1;
        if (sts.early) begin
          if (sts.ev[i2cms_pkg::E_MSTOP]) begin
            ctl.clr_early  = 1'b1;
            ctl.active_clr = 1'b1;
            ctl.finish     = 1'b1;
            ctl.fin_status = i2cms_pkg::ST_ERR;
          end
          state_nxt = S_OUT;
        end else if ((sts.ev & i2cms_pkg::E_ERRS) != 8'h00) begin
          ctl.cmd_or     = i2cms_pkg::C_ABORT;
          ctl.active_clr = 1'b1;
          ctl.finish     = 1'b1;
          ctl.fin_status = i2cms_pkg::ST_ERR;
          state_nxt      = S_OUT;
        end else begin
          state_nxt = sts.ev[i2cms_pkg::E_RXDATAV] ? S_A1 : S_B;
        end
      end
      // received byte handling
      S_A1: begin
        if (sts.bytes_zero) begin
          ret_nxt   = S_A2;
          state_nxt = S_SK_RD;
        end else begin
          state_nxt = S_A2;
        end
      end
      S_A2: begin
        if (!sts.bytes_zero) begin
          ctl.store_rx = 1'b1;
          state_nxt    = S_A2B;
        end else begin
          state_nxt = S_A3;
        end
      end
      S_A2B: begin
        if (sts.bytes_zero) begin
          ret_nxt   = S_A3;
          state_nxt = S_SK_RD;
        end else begin
          state_nxt = S_A3;
        end
      end
      S_A3: begin
        if (!sts.bytes_zero) begin
          ctl.cmd_or = i2cms_pkg::C_ACK;
          state_nxt  = S_B;
        end else if (sts.msgs_one || sts.cache_flags[i2cms_pkg::F_STOP]) begin
          ctl.cmd_or = i2cms_pkg::C_NACK | i2cms_pkg::C_STOP;
          state_nxt  = S_B;
        end else begin
          ret_nxt   = S_A4;
          state_nxt = S_AD_CHK;
        end
      end
      S_A4: begin
        ctl.send_addr = 1'b1;
        ctl.cmd_or    = i2cms_pkg::C_NACK;
        state_nxt     = S_B;
      end
      // ack and nack handling
      S_B: begin
        if (sts.ev[i2cms_pkg::E_NACK] && !sts.cache_flags[i2cms_pkg::F_IGNAK]) begin
          ctl.set_early = 1'b1;
          ctl.cmd_or    = i2cms_pkg::C_STOP;
          state_nxt     = S_C;
        end else if (sts.ev[i2cms_pkg::E_ACK] || sts.ev[i2cms_pkg::E_NACK]) begin
          if (sts.bytes_zero) begin
            ret_nxt   = S_B2;
            state_nxt = S_SK_RD;
          end else begin
            state_nxt = S_B2;
          end
        end else begin
          state_nxt = S_C;
        end
      end
      S_B2: begin
        if (sts.bytes_zero) begin
          if (sts.cache_flags[i2cms_pkg::F_STOP] || sts.msgs_one) begin
            ctl.cmd_or = i2cms_pkg::C_STOP;
            state_nxt  = S_C;
          end else begin
            ret_nxt   = S_B3;
            state_nxt = S_AD_CHK;
          end
        end else if (!sts.cache_flags[i2cms_pkg::F_RD]) begin
          state_nxt = S_B4;
        end else begin
          if (sts.ev[i2cms_pkg::E_NACK]) ctl.cmd_or = i2cms_pkg::C_CONT;
          state_nxt = S_C;
        end
      end
      S_B3: begin
        ctl.send_addr = 1'b1;
        state_nxt     = S_C;
      end
      S_B4: begin
        ctl.tx_data = 1'b1;
        state_nxt   = S_C;
      end
      // stop reported by the core
      S_C: begin
        if (sts.ev[i2cms_pkg::E_MSTOP]) begin
          ret_nxt   = S_C2;
          state_nxt = S_AD_CHK;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_C2: begin
        if (sts.msgs_zero) begin
          ctl.active_clr = 1'b1;
          ctl.finish     = 1'b1;
          ctl.fin_status = i2cms_pkg::ST_OK;
        end else begin
          ctl.send_addr = 1'b1;
        end
        state_nxt = S_OUT;
      end
      // skip empty continuation messages
      S_SK_RD: begin
        ctl.rd_sel = i2cms_pkg::RD_SUCC;
        state_nxt  = S_SK_CHK;
      end
      S_SK_CHK: begin
        if (skip_go) begin
          ctl.cur_succ = 1'b1;
          ctl.load_msg = 1'b1;
          ctl.cache_ld = 1'b1;
          state_nxt    = S_SK_RD;
        end else begin
          state_nxt = ret_r;
        end
      end
      // advance to the next message that is not an empty continuation
      S_AD_CHK: begin
        if (sts.msgs_zero) begin
          ctl.bytes_clr = 1'b1;
          state_nxt     = ret_r;
        end else begin
          ctl.rd_sel   = i2cms_pkg::RD_SUCC;
          ctl.cur_succ = 1'b1;
          state_nxt    = S_AD_RD;
        end
      end
      S_AD_RD: begin
        ctl.cache_ld = 1'b1;
        if (adv_brk || sts.msgs_zero) begin
          if (sts.msgs_zero) ctl.bytes_clr = 1'b1;
          else ctl.load_msg = 1'b1;
          state_nxt = ret_r;
        end else begin
          state_nxt = S_AD_CHK;
        end
      end
      S_OUT: begin
        if (sts.out_free) begin
          ctl.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ret_r   <= S_IDLE;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
    end
  end

endmodule
